// ===== rtl/nco_complex_frequency_shifter_defines.svh =====
// ----------------------------------------------------------------------------
// NCO complex frequency shifter assertion macros
// Shared assertion forms for the frequency shifter, clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NCO_COMPLEX_FREQUENCY_SHIFTER_DEFINES_SVH
`define NCO_COMPLEX_FREQUENCY_SHIFTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NCO_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NCO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/nco_cfs_pkg.sv =====
// ----------------------------------------------------------------------------
// NCO complex frequency shifter package
// Widths, register indexes and the elaboration-time sine/cosine table builder.
// ----------------------------------------------------------------------------
package nco_cfs_pkg;

    localparam int TABLE_BITS_DEF = 10;
    localparam int PHASE_BITS_DEF = 48;
    localparam int SAMPLE_W       = 16;
    localparam int REG_W          = 48;
    localparam int APB_DW         = 64;
    localparam int APB_AW         = 4;
    localparam int REG_IDX_BIT    = 3;
    localparam int PROD_W         = 2 * SAMPLE_W;
    localparam int SUM_W          = PROD_W + 1;
    localparam int RND_W          = SUM_W + 1;
    localparam int SHR_W          = RND_W - (SAMPLE_W - 1);

    localparam logic REG_PHASE_STEP = 1'b0;
    localparam logic REG_STEP_RATE  = 1'b1;

    localparam logic [63:0] HALFPI_Q62 = 64'h6487ED5110B4611A;
    localparam logic [63:0] ONE_Q31    = 64'h0000_0000_8000_0000;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    function automatic t_sample q31_to_q15(input logic signed [63:0] v);
        logic signed [63:0] w;
        logic signed [63:0] p;
        w = v;
        if (w < 0) begin
            w = 0;
        end
        if (w > $signed(ONE_Q31)) begin
            w = $signed(ONE_Q31);
        end
        p = (w * 64'sd32767 + 64'sd1073741824) >>> 31;
        return p[SAMPLE_W-1:0];
    endfunction

    // Returns {cos, sin} for entry k of a table with 2^tb entries.
    function automatic logic [2*SAMPLE_W-1:0] rom_word(input int unsigned tb,
                                                       input int unsigned k);
        int unsigned        quarter;
        int unsigned        quad;
        int unsigned        r;
        int unsigned        arg;
        int unsigned        sh;
        logic               flip;
        logic [63:0]        a;
        logic [63:0]        x2;
        logic [63:0]        ts;
        logic [63:0]        tc;
        logic signed [63:0] ss;
        logic signed [63:0] sc;
        t_sample            s0;
        t_sample            c0;
        t_sample            s;
        t_sample            c;
        t_sample            co;
        t_sample            so;
        quarter = 1 << (tb - 2);
        quad    = (k >> (tb - 2)) & 3;
        r       = k & (quarter - 1);
        if (r <= (quarter >> 1)) begin
            arg  = r;
            flip = 1'b0;
        end else begin
            arg  = quarter - r;
            flip = 1'b1;
        end
        sh = tb - 2 + 14;
        a  = ((HALFPI_Q62 >> 17) * 64'(arg) + (64'd1 << (sh - 1))) >> sh;
        x2 = (a * a) >> 31;
        ts = a;
        tc = ONE_Q31;
        ss = $signed(a);
        sc = $signed(ONE_Q31);
        ts = ((ts * x2) >> 31) / 64'd6;   tc = ((tc * x2) >> 31) / 64'd2;
        ss = ss - $signed(ts);            sc = sc - $signed(tc);
        ts = ((ts * x2) >> 31) / 64'd20;  tc = ((tc * x2) >> 31) / 64'd12;
        ss = ss + $signed(ts);            sc = sc + $signed(tc);
        ts = ((ts * x2) >> 31) / 64'd42;  tc = ((tc * x2) >> 31) / 64'd30;
        ss = ss - $signed(ts);            sc = sc - $signed(tc);
        ts = ((ts * x2) >> 31) / 64'd72;  tc = ((tc * x2) >> 31) / 64'd56;
        ss = ss + $signed(ts);            sc = sc + $signed(tc);
        ts = ((ts * x2) >> 31) / 64'd110; tc = ((tc * x2) >> 31) / 64'd90;
        ss = ss - $signed(ts);            sc = sc - $signed(tc);
        ts = ((ts * x2) >> 31) / 64'd156; tc = ((tc * x2) >> 31) / 64'd132;
        ss = ss + $signed(ts);            sc = sc + $signed(tc);
        ts = ((ts * x2) >> 31) / 64'd210; tc = ((tc * x2) >> 31) / 64'd182;
        ss = ss - $signed(ts);            sc = sc - $signed(tc);
        s0 = q31_to_q15(ss);
        c0 = q31_to_q15(sc);
        if (flip) begin
            s = c0;
            c = s0;
        end else begin
            s = s0;
            c = c0;
        end
        case (quad)
            0: begin
                co = c;
                so = s;
            end
            1: begin
                co = -s;
                so = c;
            end
            2: begin
                co = -c;
                so = -s;
            end
            default: begin
                co = s;
                so = -c;
            end
        endcase
        return {co, so};
    endfunction

    function automatic t_sample sat16(input logic signed [SHR_W-1:0] v);
        t_sample res;
        if (v > SHR_W'(32767)) begin
            res = 16'sh7FFF;
        end else if (v < -SHR_W'(32768)) begin
            res = 16'sh8000;
        end else begin
            res = v[SAMPLE_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/nco_cfs_ifs.sv =====
// ----------------------------------------------------------------------------
// NCO complex frequency shifter stream interfaces
// Valid/ready channels for input samples and mixed output samples.
// ----------------------------------------------------------------------------
interface nco_cfs_in_if;
    import nco_cfs_pkg::*;

    logic    valid;
    logic    ready;
    t_sample in_i;
    t_sample in_q;
    logic    in_last;

    modport source (output valid, output in_i, output in_q, output in_last, input ready);
    modport sink   (input valid, input in_i, input in_q, input in_last, output ready);
endinterface

interface nco_cfs_out_if;
    import nco_cfs_pkg::*;

    logic    valid;
    logic    ready;
    t_sample out_i;
    t_sample out_q;
    logic    out_last;

    modport source (output valid, output out_i, output out_q, output out_last, input ready);
    modport sink   (input valid, input out_i, input out_q, input out_last, output ready);
endinterface

// ===== rtl/nco_complex_frequency_shifter.sv =====
// ----------------------------------------------------------------------------
// NCO complex frequency shifter
// Mixes each complex sample with a table-based oscillator whose step can
// sweep linearly, with rounding and saturation back to Q1.15.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// i_in      in         valid/ready        in_i, in_q, in_last
// o_out     out        valid/ready        out_i, out_q, out_last
// APB       in/out     psel/penable/pready phase_step at 0x0, step_rate at 0x8
//
// One word is accepted per cycle while the pipeline is not backed up from o_out.
// The stages are the table read, the four multiplies and the round/saturate.
// Each stage moves when the one after it is empty or moving, so bubbles close.
// Reset clears the oscillator, the registers and all stage valid flags.
// ----------------------------------------------------------------------------
`include "nco_complex_frequency_shifter_defines.svh"

module nco_complex_frequency_shifter #(
    parameter int TABLE_BITS = nco_cfs_pkg::TABLE_BITS_DEF,
    parameter int PHASE_BITS = nco_cfs_pkg::PHASE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    nco_cfs_in_if.sink                       i_in,
    nco_cfs_out_if.source                    o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [nco_cfs_pkg::APB_AW-1:0]   paddr,
    input  logic [nco_cfs_pkg::APB_DW-1:0]   pwdata,
    output logic [nco_cfs_pkg::APB_DW-1:0]   prdata,
    output logic                             pready
);
    import nco_cfs_pkg::*;

    localparam int TBL_SIZE = 1 << TABLE_BITS;

    typedef logic [2*SAMPLE_W-1:0] t_rom [TBL_SIZE];

    function automatic t_rom build_rom();
        t_rom tbl;
        for (int k = 0; k < TBL_SIZE; k++) begin
            tbl[k] = rom_word(TABLE_BITS, k);
        end
        return tbl;
    endfunction

    localparam t_rom ROM_INIT = build_rom();

    logic [REG_W-1:0]      r_phase_step;
    logic [REG_W-1:0]      r_step_rate;
    logic [PHASE_BITS-1:0] r_phase_acc;
    logic [PHASE_BITS-1:0] r_step_now;
    logic [PHASE_BITS-1:0] n_phase_acc;
    logic [PHASE_BITS-1:0] n_step_now;

    logic                  cfg_wr;
    logic                  in_fire;
    logic                  adv1;
    logic                  adv2;
    logic                  adv3;
    logic [TABLE_BITS-1:0] rom_idx;

    logic                  r_s1_v;
    t_sample               r_s1_i;
    t_sample               r_s1_q;
    logic                  r_s1_last;
    logic [2*SAMPLE_W-1:0] r_s1_cs;

    logic                     r_s2_v;
    logic                     r_s2_last;
    logic signed [PROD_W-1:0] r_p_ic;
    logic signed [PROD_W-1:0] r_p_qs;
    logic signed [PROD_W-1:0] r_p_qc;
    logic signed [PROD_W-1:0] r_p_is;

    logic                     r_s3_v;
    t_sample                  r_s3_i;
    t_sample                  r_s3_q;
    logic                     r_s3_last;

    t_sample                  s1_cos;
    t_sample                  s1_sin;
    logic signed [SUM_W-1:0]  sum_i;
    logic signed [SUM_W-1:0]  sum_q;
    logic signed [RND_W-1:0]  rnd_i;
    logic signed [RND_W-1:0]  rnd_q;
    logic signed [SHR_W-1:0]  shr_i;
    logic signed [SHR_W-1:0]  shr_q;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign adv3    = !r_s3_v || o_out.ready;
    assign adv2    = !r_s2_v || adv3;
    assign adv1    = !r_s1_v || adv2;
    assign i_in.ready = adv1;
    assign in_fire = i_in.valid && adv1;
    assign rom_idx = r_phase_acc[PHASE_BITS-1 -: TABLE_BITS];

    always_comb begin
        case (paddr[REG_IDX_BIT])
            REG_PHASE_STEP: prdata = APB_DW'(r_phase_step);
            default:        prdata = APB_DW'(r_step_rate);
        endcase
    end

    always_comb begin
        n_phase_acc = r_phase_acc;
        n_step_now  = r_step_now;
        if (in_fire) begin
            n_phase_acc = r_phase_acc + r_step_now;
            n_step_now  = r_step_now + r_step_rate[PHASE_BITS-1:0];
        end
        if (cfg_wr && paddr[REG_IDX_BIT] == REG_PHASE_STEP) begin
            n_step_now = pwdata[PHASE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0;
            r_step_rate  <= '0;
            r_phase_acc  <= '0;
            r_step_now   <= '0;
        end else begin
            r_phase_acc <= n_phase_acc;
            r_step_now  <= n_step_now;
            if (cfg_wr) begin
                case (paddr[REG_IDX_BIT])
                    REG_PHASE_STEP: r_phase_step <= pwdata[REG_W-1:0];
                    default:        r_step_rate  <= pwdata[REG_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (adv1) begin
                r_s1_v <= i_in.valid;
            end
            if (adv2) begin
                r_s2_v <= r_s1_v;
            end
            if (adv3) begin
                r_s3_v <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1_cs   <= ROM_INIT[rom_idx];
            r_s1_i    <= i_in.in_i;
            r_s1_q    <= i_in.in_q;
            r_s1_last <= i_in.in_last;
        end
    end

    assign s1_cos = r_s1_cs[2*SAMPLE_W-1:SAMPLE_W];
    assign s1_sin = r_s1_cs[SAMPLE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_p_ic    <= r_s1_i * s1_cos;
            r_p_qs    <= r_s1_q * s1_sin;
            r_p_qc    <= r_s1_q * s1_cos;
            r_p_is    <= r_s1_i * s1_sin;
            r_s2_last <= r_s1_last;
        end
    end

    always_comb begin
        sum_i = SUM_W'(r_p_ic) - SUM_W'(r_p_qs);
        sum_q = SUM_W'(r_p_qc) + SUM_W'(r_p_is);
        rnd_i = RND_W'(sum_i) + RND_W'(1 << (SAMPLE_W - 2));
        rnd_q = RND_W'(sum_q) + RND_W'(1 << (SAMPLE_W - 2));
        shr_i = SHR_W'(rnd_i >>> (SAMPLE_W - 1));
        shr_q = SHR_W'(rnd_q >>> (SAMPLE_W - 1));
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_s3_i    <= sat16(shr_i);
            r_s3_q    <= sat16(shr_q);
            r_s3_last <= r_s2_last;
        end
    end

    assign o_out.valid    = r_s3_v;
    assign o_out.out_i    = r_s3_i;
    assign o_out.out_q    = r_s3_q;
    assign o_out.out_last = r_s3_last;

    `NCO_ASSERT_NEXT(a_phase_adv, i_rst_n && in_fire, r_phase_acc == $past(r_phase_acc + r_step_now), "phase did not advance by the current step")
    `NCO_ASSERT_NEXT(a_phase_hold, i_rst_n && !in_fire, r_phase_acc == $past(r_phase_acc), "phase moved without an accepted word")
    `NCO_ASSERT_NEXT(a_step_load, i_rst_n && cfg_wr && paddr[REG_IDX_BIT] == REG_PHASE_STEP, r_step_now == $past(pwdata[PHASE_BITS-1:0]), "phase step write did not load the current step")
    `NCO_ASSERT_SAME(a_full_stall, r_s1_v && r_s2_v && r_s3_v && !o_out.ready, !i_in.ready, "input taken while the pipeline is full and stalled")
    `NCO_ASSERT_NEXT(a_out_from_s2, i_rst_n && r_s2_v && adv3, r_s3_v, "stage two word lost on its way to the output")

endmodule
